// ===== rtl/bnssf_pkg.sv =====
// Shared types, constants and glyph table for the seven-segment formatter.
`default_nettype none
package bnssf_pkg;

	typedef enum logic [1:0] {
		RANGE_OK   = 2'd0,
		RANGE_HIGH = 2'd1,
		RANGE_LOW  = 2'd2
	} range_t;

	typedef struct packed {
		range_t rng;
		logic   neg;
		logic   whole;
	} ctrl_t;

	localparam logic signed [15:0] HIGH_LIMIT  = 16'sd19995;
	localparam logic signed [15:0] LOW_LIMIT   = -16'sd995;
	localparam logic signed [15:0] POINT_HIGH  = 16'sd1999;
	localparam logic signed [15:0] POINT_LOW   = -16'sd99;
	localparam logic [15:0]        ROUND_HALF  = 16'd5;

	localparam logic [15:0] DIV10_RECIP = 16'd52429;
	localparam int          DIV10_SHIFT = 19;
	localparam logic [7:0]  DIV10_SMALL = 8'd205;
	localparam int          SMALL_SHIFT = 11;

	localparam logic [10:0] MAX_MAG = 11'd2000;

	localparam logic [7:0] GLYPH_H      = 8'h67;
	localparam logic [7:0] GLYPH_I      = 8'h40;
	localparam logic [7:0] GLYPH_L      = 8'hE0;
	localparam logic [7:0] GLYPH_O      = 8'hC6;
	localparam logic [7:0] GLYPH_ZERO   = 8'hF5;
	localparam logic [7:0] POINT_BIT    = 8'h08;
	localparam logic [7:0] MINUS_BIT    = 8'h02;
	localparam logic [7:0] THOUSAND_BIT = 8'h08;

	function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
		logic [7:0] g;
		case (digit)
			4'd0: g = 8'hF5;
			4'd1: g = 8'h05;
			4'd2: g = 8'hD3;
			4'd3: g = 8'h97;
			4'd4: g = 8'h27;
			4'd5: g = 8'hB6;
			4'd6: g = 8'hF6;
			4'd7: g = 8'h15;
			4'd8: g = 8'hF7;
			4'd9: g = 8'hB7;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/big_number_seven_segment_format.sv =====
// Top level: four-stage pipeline that formats a value in tenths for a 3-digit display.
//
// Input channel: item_valid / item_stall carry value_tenths (signed tenths)
// and symbol_code. Output channel: result_valid / result_stall carry seg_low,
// seg_mid, seg_high, symbol_bits and range_flag, one result per item.
// An item moves on at an edge where its valid is high and its stall is low.
// An accepted item passes through the stage 1 to stage 4 registers, the last
// of which drives the outputs; throughput is one item per cycle while
// result_stall is low. Stage 1 classifies the value and forms the rounded
// magnitude, stage 2 divides whole values by ten with a reciprocal multiply,
// stage 3 takes the tens quotient with a second multiply, stage 4 splits the
// digits, looks up the glyphs and holds the result in the output register.
// Reset clears all stage valid bits; the payload registers are not reset.
// When the receiver stalls, the result holds and each stage keeps its item
// until the stage after it frees up; item_stall rises only once stage 1 is
// occupied and cannot move on.
`default_nettype none
module big_number_seven_segment_format (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [15:0] value_tenths,
	input  wire logic [2:0]  symbol_code,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic      [7:0]  seg_low,
	output logic      [7:0]  seg_mid,
	output logic      [7:0]  seg_high,
	output logic      [2:0]  symbol_bits,
	output logic      [1:0]  range_flag
);
	import bnssf_pkg::*;

	logic en_s1, en_s2, en_s3, en_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic signed [15:0] v;
	logic [15:0] absv;
	logic [15:0] adj;
	ctrl_t       ctrl_in;

	logic [14:0] a_s1;
	ctrl_t       ctrl_s1;
	logic [2:0]  sym_s1;

	logic [30:0] prod_s2;
	logic [10:0] mag_in_s2;
	logic [10:0] mag_s2;
	ctrl_t       ctrl_s2;
	logic [2:0]  sym_s2;

	logic [26:0] prod_s3;
	logic [10:0] mag_s3;
	logic [7:0]  q1_s3;
	ctrl_t       ctrl_s3;
	logic [2:0]  sym_s3;

	logic [7:0]  enc_low, enc_mid, enc_high;
	logic [7:0]  seg_low_s4, seg_mid_s4, seg_high_s4;
	logic [2:0]  sym_s4;
	range_t      rng_s4;

	assign en_s4 = !valid_s4 || !result_stall;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign item_stall = !en_s1;

	assign v    = value_tenths;
	assign absv = v[15] ? (~value_tenths + 16'd1) : value_tenths;

	always_comb begin
		ctrl_in.neg   = v[15];
		ctrl_in.whole = (v > POINT_HIGH) || (v < POINT_LOW);
		if (v > HIGH_LIMIT) begin
			ctrl_in.rng = RANGE_HIGH;
		end else if (v < LOW_LIMIT) begin
			ctrl_in.rng = RANGE_LOW;
		end else begin
			ctrl_in.rng = RANGE_OK;
		end
		adj = ctrl_in.whole ? (absv + ROUND_HALF) : absv;
	end

	assign prod_s2   = 31'(a_s1) * 31'(DIV10_RECIP);
	assign mag_in_s2 = ctrl_s1.whole ? prod_s2[DIV10_SHIFT +: 11] : a_s1[10:0];
	assign prod_s3   = 27'(mag_s2) * 27'(DIV10_RECIP);

	bnssf_encode u_encode (
		.ctrl     (ctrl_s3),
		.mag      (mag_s3),
		.q1       (q1_s3),
		.seg_low  (enc_low),
		.seg_mid  (enc_mid),
		.seg_high (enc_high)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= item_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_s1    <= adj[14:0];
			ctrl_s1 <= ctrl_in;
			sym_s1  <= symbol_code;
		end
		if (en_s2) begin
			mag_s2  <= mag_in_s2;
			ctrl_s2 <= ctrl_s1;
			sym_s2  <= sym_s1;
		end
		if (en_s3) begin
			mag_s3  <= mag_s2;
			q1_s3   <= prod_s3[DIV10_SHIFT +: 8];
			ctrl_s3 <= ctrl_s2;
			sym_s3  <= sym_s2;
		end
		if (en_s4) begin
			seg_low_s4  <= enc_low;
			seg_mid_s4  <= enc_mid;
			seg_high_s4 <= enc_high;
			sym_s4      <= sym_s3;
			rng_s4      <= ctrl_s3.rng;
		end
	end

	assign result_valid = valid_s4;
	assign seg_low      = seg_low_s4;
	assign seg_mid      = seg_mid_s4;
	assign seg_high     = seg_high_s4;
	assign symbol_bits  = sym_s4;
	assign range_flag   = rng_s4;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && result_stall))
		else $error("input stalled with room in the pipeline");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ctrl_s2.rng == RANGE_OK) |-> (mag_s2 <= MAX_MAG))
		else $error("magnitude out of display range");

	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && ctrl_s3.rng == RANGE_OK) |->
		((12'(q1_s3) * 12'd10 <= 12'(mag_s3)) && (12'(mag_s3) < 12'(q1_s3) * 12'd10 + 12'd10)))
		else $error("tens quotient wrong");

	a_high_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && range_flag == RANGE_HIGH) |->
		(seg_high == GLYPH_H && seg_mid == GLYPH_I && seg_low == 8'h00))
		else $error("too-high display wrong");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en_s4) |=> valid_s4)
		else $error("item lost between stage 3 and output");

endmodule
`default_nettype wire

// ===== rtl/bnssf_encode.sv =====
// Digit split and segment byte assembly for the last pipeline stage.
`default_nettype none
module bnssf_encode (
	input  var bnssf_pkg::ctrl_t ctrl,
	input  wire logic [10:0]     mag,
	input  wire logic [7:0]      q1,
	output logic      [7:0]      seg_low,
	output logic      [7:0]      seg_mid,
	output logic      [7:0]      seg_high
);
	import bnssf_pkg::*;

	logic [15:0] q2_prod;
	logic [4:0]  q2;
	logic [10:0] ones_full;
	logic [7:0]  tens_full;
	logic [3:0]  ones;
	logic [3:0]  tens;
	logic [3:0]  hund;

	assign q2_prod   = 16'(q1) * 16'(DIV10_SMALL);
	assign q2        = q2_prod[SMALL_SHIFT +: 5];
	assign ones_full = mag - 11'(q1) * 11'd10;
	assign tens_full = q1 - 8'(q2) * 8'd10;
	assign ones      = ones_full[3:0];
	assign tens      = tens_full[3:0];

	always_comb begin
		if (q2 >= 5'd20) begin
			hund = 4'(q2 - 5'd20);
		end else if (q2 >= 5'd10) begin
			hund = 4'(q2 - 5'd10);
		end else begin
			hund = q2[3:0];
		end
	end

	always_comb begin
		seg_low  = 8'h00;
		seg_mid  = 8'h00;
		seg_high = 8'h00;
		unique case (ctrl.rng)
			RANGE_HIGH: begin
				seg_mid  = GLYPH_I;
				seg_high = GLYPH_H;
			end
			RANGE_LOW: begin
				seg_mid  = GLYPH_O;
				seg_high = GLYPH_L;
			end
			default: begin
				seg_low = digit_glyph(ones);
				seg_mid = ctrl.whole ? 8'h00 : POINT_BIT;
				if (mag > 11'd9) begin
					seg_mid = seg_mid | digit_glyph(tens);
				end else begin
					seg_mid = seg_mid | GLYPH_ZERO;
				end
				if (ctrl.neg) begin
					seg_high = seg_high | MINUS_BIT;
				end
				if (mag > 11'd999) begin
					seg_high = seg_high | THOUSAND_BIT;
				end
				if (mag > 11'd99) begin
					seg_high = seg_high | digit_glyph(hund);
				end
			end
		endcase
	end

endmodule
`default_nettype wire
